// ===== hdl/svt_pkg.sv =====
// Shared types and constants for the sorted version table.
package svt_pkg;

	localparam int DEPTH_DEF = 256;
	// cells combined per group in the first reduction stage
	localparam int GROUP = 16;
	localparam int TW = 32;
	localparam int IDW = 31;
	localparam int OUT_CW = 9;

	typedef struct packed {
		logic [IDW-1:0] rev_id;
		logic [TW-1:0]  start;
		logic [TW-1:0]  stop;
		logic [IDW-1:0] frequency;
	} entry_t;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic cmp;
		logic grp;
		logic fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

// ===== hdl/svt_ctrl.sv =====
// Sequencer for the sorted version table: load, compare, reduce, finish.
module svt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  svt_pkg::stat_t stat,
	output svt_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_GRP, S_FIN} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CMP;
				S_CMP:  state_q <= S_GRP;
				S_GRP:  state_q <= S_FIN;
				S_FIN:  if (!stat.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_CMP: cmd.cmp = 1'b1;
			S_GRP: cmd.grp = 1'b1;
			S_FIN: cmd.fin = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/svt_dp.sv =====
// Datapath: sorted cell row, parallel compare, two-stage select tree, result register.
module svt_dp #(
	parameter int DEPTH = svt_pkg::DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  svt_pkg::cmd_t   cmd,
	output svt_pkg::stat_t  stat,
	input  logic            in_kind,
	input  logic [31:0]     in_key,
	input  svt_pkg::entry_t in_entry,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [8:0]      out_position,
	output logic            out_entry_valid,
	output svt_pkg::entry_t out_entry,
	output logic [8:0]      out_count,
	output logic            out_dropped,
	output logic [31:0]     out_low,
	output logic [31:0]     out_high
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int NG = (DEPTH + svt_pkg::GROUP - 1) / svt_pkg::GROUP;

	svt_pkg::entry_t cells_q [DEPTH];
	logic [CW-1:0]   count_q;
	logic [31:0]     low_q, high_q;
	logic            kind_q;
	logic [31:0]     key_q;
	svt_pkg::entry_t new_q;
	logic [DEPTH-1:0] less_q, sel_q;
	svt_pkg::entry_t grp_ent_q [NG];
	logic [IW-1:0]   grp_idx_q [NG];
	logic [NG-1:0]   grp_hit_q;

	logic [DEPTH-1:0] less_c, sel_c;
	svt_pkg::entry_t  sel_ent;
	logic [IW-1:0]    sel_idx;
	logic             hit;
	logic [CW-1:0]    pos;
	logic             full, do_ins;

	assign stat.out_busy = out_valid && !out_ready;

	// per-cell compare against the item key; only occupied cells count
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			less_c[i] = (CW'(i) < count_q) && ($signed(cells_q[i].start) < $signed(key_q));
		end
		for (int i = 0; i < DEPTH; i++) begin
			sel_c[i] = (CW'(i) < count_q) && !less_c[i] && ((i == 0) || less_c[(i == 0) ? 0 : i-1]);
		end
	end

	// item capture and compare results; the entry start field carries the key
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			key_q  <= in_key;
			new_q  <= in_entry;
		end
		if (cmd.cmp) begin
			less_q <= less_c;
			sel_q  <= sel_c;
		end
	end

	// first reduction stage: one-hot select inside each group
	always_ff @(posedge clk) begin
		if (cmd.grp) begin
			for (int g = 0; g < NG; g++) begin
				svt_pkg::entry_t e;
				logic [IW-1:0]   x;
				logic            h;
				e = '0;
				x = '0;
				h = 1'b0;
				for (int k = 0; k < svt_pkg::GROUP; k++) begin
					if (g * svt_pkg::GROUP + k < DEPTH) begin
						if (sel_q[g * svt_pkg::GROUP + k]) begin
							e = e | cells_q[g * svt_pkg::GROUP + k];
							x = x | IW'(g * svt_pkg::GROUP + k);
							h = 1'b1;
						end
					end
				end
				grp_ent_q[g] <= e;
				grp_idx_q[g] <= x;
				grp_hit_q[g] <= h;
			end
		end
	end

	// second reduction stage across groups
	always_comb begin
		sel_ent = '0;
		sel_idx = '0;
		for (int g = 0; g < NG; g++) begin
			sel_ent = sel_ent | grp_ent_q[g];
			sel_idx = sel_idx | grp_idx_q[g];
		end
		hit    = |grp_hit_q;
		pos    = hit ? CW'(sel_idx) : count_q;
		full   = (count_q == CW'(DEPTH));
		do_ins = (kind_q == svt_pkg::KIND_INSERT) && !full;
	end

	// insert shift: cells at and above the position move up one
	always_ff @(posedge clk) begin
		if (cmd.fin && do_ins) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!less_q[i]) begin
					if (i == 0 || less_q[(i == 0) ? 0 : i-1]) begin
						cells_q[i] <= new_q;
					end else begin
						cells_q[i] <= cells_q[(i == 0) ? 0 : i-1];
					end
				end
			end
		end
	end

	// count, bounds and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			low_q     <= '0;
			high_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.fin) begin
				out_valid <= 1'b1;
				if (do_ins) begin
					count_q <= count_q + 1'b1;
					if (count_q == '0) begin
						low_q  <= key_q;
						high_q <= key_q;
					end else begin
						if ($signed(key_q) < $signed(low_q)) low_q <= key_q;
						if ($signed(high_q) < $signed(key_q)) high_q <= key_q;
					end
				end
			end
		end
	end

	logic [31:0] low_n, high_n;
	always_comb begin
		low_n  = low_q;
		high_n = high_q;
		if (do_ins) begin
			if (count_q == '0) begin
				low_n  = key_q;
				high_n = key_q;
			end else begin
				if ($signed(key_q) < $signed(low_q)) low_n = key_q;
				if ($signed(high_q) < $signed(key_q)) high_n = key_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_position    <= 9'(pos);
			out_entry_valid <= do_ins || hit;
			out_entry       <= do_ins ? new_q : sel_ent;
			out_count       <= 9'(count_q + CW'(do_ins));
			out_dropped     <= (kind_q == svt_pkg::KIND_INSERT) && full;
			out_low         <= low_n;
			out_high        <= high_n;
		end
	end

endmodule

// ===== hdl/sorted_version_table.sv =====
// Sorted version table top: keeps entries ordered by start time, answers lower-bound queries.
// An accepted item passes through the compare, group select and finish steps before the result is valid.
// No new item is accepted until the previous one has passed the compare, two-stage select tree and finish sequence.
// The finish step waits while the result register still holds an untaken result.
// Reset (arst_n low, asynchronous): count and bounds clear, no result pending;
// table cells are not cleared and are read only below the count.
module sorted_version_table #(
	parameter int DEPTH = svt_pkg::DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // key_time[31:0] rev_id[62:32] stop_time[94:63] frequency[125:95]
	input  logic         s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [207:0] m_tdata,  // position, entry_rev_id, entry_start, entry_stop,
	                               // entry_frequency, entry_count, low_point, high_point
	output logic [1:0]   m_tuser   // entry_valid[0] dropped_full[1]
);

	svt_pkg::cmd_t   cmd;
	svt_pkg::stat_t  stat;
	svt_pkg::entry_t in_entry, out_entry;
	logic [8:0]      out_position, out_count;
	logic            out_entry_valid, out_dropped;
	logic [31:0]     out_low, out_high;

	assign in_entry.rev_id    = s_tdata[62:32];
	assign in_entry.start     = s_tdata[31:0];
	assign in_entry.stop      = s_tdata[94:63];
	assign in_entry.frequency = s_tdata[125:95];

	svt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	svt_dp #(.DEPTH(DEPTH)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_kind         (s_tuser),
		.in_key          (s_tdata[31:0]),
		.in_entry        (in_entry),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_position    (out_position),
		.out_entry_valid (out_entry_valid),
		.out_entry       (out_entry),
		.out_count       (out_count),
		.out_dropped     (out_dropped),
		.out_low         (out_low),
		.out_high        (out_high)
	);

	assign m_tdata = {out_high, out_low, out_count, out_entry.frequency, out_entry.stop,
	                  out_entry.start, out_entry.rev_id, out_position};
	assign m_tuser = {out_dropped, out_entry_valid};

	// only one sequencer command at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.cmp, cmd.grp, cmd.fin}))
		else $error("more than one command active");

	// an accepted item closes the input until it finishes
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input reopened during item");

	// a finish never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(m_tvalid && !m_tready))
		else $error("result overwritten");

	// a refused insert only happens on a full table
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata[143:135] == 9'(DEPTH)))
		else $error("drop with free space");

endmodule
